[src/rwbm_pkg.sv]
package rwbm_pkg;

   // Field and register widths.
   localparam int COORD_W    = 12;
   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 3 * CHAN_W;
   localparam int CFG_SRC_W  = 9;
   localparam int CFG_DST_W  = 13;
   localparam int CSR_DATA_W = CFG_DST_W;

   // Serial divider sizes: the dividend is a coordinate times a source size.
   localparam int DIVIDEND_W = COORD_W + CFG_SRC_W;
   localparam int DIVISOR_W  = CFG_DST_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   // A channel sum over nine pixels stays below 9 * 256.
   localparam int SUM_W   = 12;
   localparam int RECIP_W = 12;
   localparam int PROD_W  = SUM_W + RECIP_W;

   // floor(s / 9) equals (s * 3641) >> 15 for every s below 4096.
   localparam logic [RECIP_W-1:0] BOX_RECIP = 12'd3641;
   localparam int                 BOX_SHIFT = 15;

   localparam logic [CFG_SRC_W-1:0] SRC_SIZE_RESET = 9'd256;
   localparam logic [CFG_DST_W-1:0] DST_SIZE_RESET = 13'd256;

   typedef enum logic [0:0] {
      OP_STORE   = 1'b0,
      OP_COMPUTE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [CHAN_W-1:0]   in_red;
      logic [CHAN_W-1:0]   in_green;
      logic [CHAN_W-1:0]   in_blue;
   } req_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;
      logic div_start;
      logic prep;
      logic read;
      logic load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic last_tap;
      logic out_free;
   } dp_status_type;

   // Truncated mean of a nine-pixel channel sum.
   function automatic logic [CHAN_W-1:0] box_mean(input logic [SUM_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(sum) * PROD_W'(BOX_RECIP);
      return prod[BOX_SHIFT +: CHAN_W];
   endfunction

endpackage

[src/rwbm_if.sv]
// Request channel: one store or compute transaction.
interface rwbm_req_if import rwbm_pkg::*; ();
   logic               valid;
   logic               ready;
   opcode_type         opcode;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;
   logic [CHAN_W-1:0]  in_red;
   logic [CHAN_W-1:0]  in_green;
   logic [CHAN_W-1:0]  in_blue;

   modport source (output valid, opcode, col, row, in_red, in_green, in_blue,
                   input ready);
   modport sink (input valid, opcode, col, row, in_red, in_green, in_blue,
                 output ready);
endinterface

// Response channel: one averaged pixel.
interface rwbm_rsp_if import rwbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// Register write channel.
interface rwbm_csr_if import rwbm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/rwbm_divider.sv]
// Restoring divider, one quotient bit per cycle.
module rwbm_divider import rwbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);

   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;

   // Shift in the next dividend bit and subtract when the divisor fits.
   always_comb begin
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         count_in = DIV_CNT_W'(DIVIDEND_W);
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = (count_ff == '0);

endmodule

[src/rwbm_datapath.sv]
// Configuration registers, coordinate mapping, pixel store and box sums.
module rwbm_datapath import rwbm_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  req_payload_type       req,
   input  logic                  csr_write,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [CHAN_W-1:0]     out_red,
   output logic [CHAN_W-1:0]     out_green,
   output logic [CHAN_W-1:0]     out_blue
);

   localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] TAP_LO   = 2'd0;
   localparam logic [1:0] TAP_MID  = 2'd1;
   localparam logic [1:0] TAP_LAST = 2'd2;

   typedef struct packed {
      logic [CFG_SRC_W-1:0] lo;
      logic [CFG_SRC_W-1:0] mid;
      logic [CFG_SRC_W-1:0] hi;
   } nbr_type;

   // Clamped indices one before, at and one after the mapped point.
   function automatic nbr_type neighbors(input logic [DIVIDEND_W-1:0] q,
                                         input logic [CFG_SRC_W-1:0]  size);
      logic [CFG_SRC_W-1:0] last;
      logic [CFG_SRC_W-1:0] qn;
      nbr_type              n;
      last = size - 1'b1;
      qn   = q[CFG_SRC_W-1:0];
      if (q >= DIVIDEND_W'(size)) begin
         n.lo  = last;
         n.mid = last;
         n.hi  = last;
      end else begin
         n.mid = qn;
         n.lo  = (qn == '0) ? qn : qn - 1'b1;
         n.hi  = (qn == last) ? qn : qn + 1'b1;
      end
      return n;
   endfunction

   function automatic logic [CFG_SRC_W-1:0] pick(input nbr_type n, input logic [1:0] tap);
      logic [CFG_SRC_W-1:0] v;
      case (tap)
         TAP_LO:  v = n.lo;
         TAP_MID: v = n.mid;
         default: v = n.hi;
      endcase
      return v;
   endfunction

   logic [CFG_SRC_W-1:0]  src_width_ff, src_height_ff;
   logic [CFG_DST_W-1:0]  dst_width_ff, dst_height_ff;
   logic [CFG_SRC_W-1:0]  sw, sh;
   logic [CFG_DST_W-1:0]  dw, dh;
   logic [DIVIDEND_W-1:0] prod_x, prod_y, quo_x, quo_y;
   logic                  done_x, done_y;
   nbr_type               nx_ff, ny_ff;
   logic [1:0]            tx_ff, ty_ff;
   logic [CFG_SRC_W-1:0]  rx, ry;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic                  wr_en;
   logic [PIXEL_W-1:0]    mem [DEPTH];
   logic [PIXEL_W-1:0]    rd_data_ff;
   logic                  acc_en_ff;
   logic [SUM_W-1:0]      sum_r_ff, sum_g_ff, sum_b_ff;
   logic                  rsp_valid_ff;
   logic [CHAN_W-1:0]     out_red_ff, out_green_ff, out_blue_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_SIZE_RESET;
         src_height_ff <= SRC_SIZE_RESET;
         dst_width_ff  <= DST_SIZE_RESET;
         dst_height_ff <= DST_SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data[CFG_SRC_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_data[CFG_SRC_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
            CSR_DST_HEIGHT: dst_height_ff <= csr_data;
         endcase
      end
   end

   // Effective sizes: zero reads as one, the source is limited to the store.
   always_comb begin
      if (src_width_ff == '0) begin
         sw = CFG_SRC_W'(1);
      end else if (int'(src_width_ff) > MAX_SRC_WIDTH) begin
         sw = CFG_SRC_W'(MAX_SRC_WIDTH);
      end else begin
         sw = src_width_ff;
      end
      if (src_height_ff == '0) begin
         sh = CFG_SRC_W'(1);
      end else if (int'(src_height_ff) > MAX_SRC_HEIGHT) begin
         sh = CFG_SRC_W'(MAX_SRC_HEIGHT);
      end else begin
         sh = src_height_ff;
      end
      dw = (dst_width_ff == '0) ? CFG_DST_W'(1) : dst_width_ff;
      dh = (dst_height_ff == '0) ? CFG_DST_W'(1) : dst_height_ff;
   end

   // Mapping: destination coordinate times source size over destination size.
   assign prod_x = DIVIDEND_W'(req.col) * DIVIDEND_W'(sw);
   assign prod_y = DIVIDEND_W'(req.row) * DIVIDEND_W'(sh);

   rwbm_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_x),
      .divisor  (dw),
      .quotient (quo_x),
      .done     (done_x)
   );

   rwbm_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_y),
      .divisor  (dh),
      .quotient (quo_y),
      .done     (done_y)
   );

   // Neighborhood indices, then a walk over the nine taps row by row.
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         nx_ff <= neighbors(quo_x, sw);
         ny_ff <= neighbors(quo_y, sh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.prep) begin
         tx_ff <= TAP_LO;
         ty_ff <= TAP_LO;
      end else if (cmd.read) begin
         if (tx_ff == TAP_LAST) begin
            tx_ff <= TAP_LO;
            ty_ff <= ty_ff + 1'b1;
         end else begin
            tx_ff <= tx_ff + 1'b1;
         end
      end
   end

   assign rx      = pick(nx_ff, tx_ff);
   assign ry      = pick(ny_ff, ty_ff);
   assign rd_addr = ADDR_W'(ry) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(rx);

   // Stores inside the effective source size are written, others dropped.
   assign wr_en   = cmd.store && (req.col < COORD_W'(sw)) && (req.row < COORD_W'(sh));
   assign wr_addr = ADDR_W'(req.row) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(req.col);

   // Pixel store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req.in_red, req.in_green, req.in_blue};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Channel sums: each pixel is added in the cycle after its read.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         sum_r_ff <= '0;
         sum_g_ff <= '0;
         sum_b_ff <= '0;
      end else if (acc_en_ff) begin
         sum_r_ff <= sum_r_ff + SUM_W'(rd_data_ff[2*CHAN_W +: CHAN_W]);
         sum_g_ff <= sum_g_ff + SUM_W'(rd_data_ff[CHAN_W +: CHAN_W]);
         sum_b_ff <= sum_b_ff + SUM_W'(rd_data_ff[0 +: CHAN_W]);
      end
   end

   // Output register holds the result until the response transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_red_ff   <= box_mean(sum_r_ff);
         out_green_ff <= box_mean(sum_g_ff);
         out_blue_ff  <= box_mean(sum_b_ff);
      end
   end

   assign status.div_done = done_x && done_y;
   assign status.last_tap = (tx_ff == TAP_LAST) && (ty_ff == TAP_LAST);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign out_red   = out_red_ff;
   assign out_green = out_green_ff;
   assign out_blue  = out_blue_ff;

endmodule

[src/rwbm_ctrl.sv]
// Sequencer for store and compute transactions.
module rwbm_ctrl import rwbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  opcode_type    req_opcode,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_PREP   = 6'b000100,
      ST_READ   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_COMPUTE) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVIDE;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/resize_with_box_mean.sv]
// Store transaction: a new transaction may follow in the next cycle.
// Compute transaction: the bit-serial coordinate dividers run, then nine reads go
// through the single read port of the pixel store; no new request is taken until the
// result is loaded into the output register, which waits while an older result stalls.
// Reset (synchronous, active high) restores the size registers to 256 and empties the
// output register; pixel store contents are undefined until written.
module resize_with_box_mean import rwbm_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256
) (
   input logic        clock,
   input logic        reset,
   rwbm_req_if.sink   req_bus,
   rwbm_rsp_if.source rsp_bus,
   rwbm_csr_if.sink   csr_bus
);

   dp_cmd_type      cmd;
   dp_status_type   status;
   req_payload_type req;

   // Request payload as one bundle for the datapath.
   assign req.opcode   = req_bus.opcode;
   assign req.col      = req_bus.col;
   assign req.row      = req_bus.row;
   assign req.in_red   = req_bus.in_red;
   assign req.in_green = req_bus.in_green;
   assign req.in_blue  = req_bus.in_blue;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;

   rwbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   rwbm_datapath #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req),
      .csr_write (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .out_red   (rsp_bus.out_red),
      .out_green (rsp_bus.out_green),
      .out_blue  (rsp_bus.out_blue)
   );

endmodule

[src/rwbm_checker.sv]
// Port-level checks for the resize block.
module rwbm_checker import rwbm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input opcode_type        req_opcode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] out_red,
   input logic [CHAN_W-1:0] out_green,
   input logic [CHAN_W-1:0] out_blue
);

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_red) && $stable(out_green)
         && $stable(out_blue))
      else $error("response changed while stalled");

   // A compute transaction occupies the block.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_COMPUTE |=> !req_ready)
      else $error("request taken while a compute is in flight");

   // A store transaction leaves the block ready for the next one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_STORE |=> req_ready)
      else $error("store transaction stalled the request channel");

   // A new response never appears right after a request transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response appeared right after a request transaction");

endmodule

bind resize_with_box_mean rwbm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_opcode (req_bus.opcode),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .out_red    (rsp_bus.out_red),
   .out_green  (rsp_bus.out_green),
   .out_blue   (rsp_bus.out_blue)
);

[bench/resize_with_box_mean_tb.sv]
`timescale 1ns / 100ps

// Mirror of the block: size registers, pixel store and the averaged pixels still owed.
class box_mean_board;
   localparam int STORE_COLS = 256;
   localparam int STORE_ROWS = 256;
   localparam int BOX_TAPS   = 9;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   bit [8:0]  src_w_reg = 9'd256;
   bit [8:0]  src_h_reg = 9'd256;
   bit [12:0] dst_w_reg = 13'd256;
   bit [12:0] dst_h_reg = 13'd256;
   bit [23:0] pixels [STORE_COLS*STORE_ROWS];
   bit        written [STORE_COLS*STORE_ROWS];
   rgb_type   owed_pixels [$];
   int        errors;

   // Effective sizes: zero counts as one, the source is capped at the store size.
   function int src_cols();
      if (src_w_reg == 0) return 1;
      return (src_w_reg > STORE_COLS) ? STORE_COLS : int'(src_w_reg);
   endfunction

   function int src_rows();
      if (src_h_reg == 0) return 1;
      return (src_h_reg > STORE_ROWS) ? STORE_ROWS : int'(src_h_reg);
   endfunction

   function int dst_cols();
      return (dst_w_reg == 0) ? 1 : int'(dst_w_reg);
   endfunction

   function int dst_rows();
      return (dst_h_reg == 0) ? 1 : int'(dst_h_reg);
   endfunction

   function void write_reg(rwbm_pkg::csr_index_type idx, logic [12:0] data);
      case (idx)
         rwbm_pkg::CSR_SRC_WIDTH:  src_w_reg = data[8:0];
         rwbm_pkg::CSR_SRC_HEIGHT: src_h_reg = data[8:0];
         rwbm_pkg::CSR_DST_WIDTH:  dst_w_reg = data;
         default:                  dst_h_reg = data;
      endcase
   endfunction

   function bit takes_store(int col, int row);
      return (col < src_cols()) && (row < src_rows());
   endfunction

   function int clamp_to(longint v, int size);
      if (v < 0) return 0;
      if (v > size - 1) return size - 1;
      return int'(v);
   endfunction

   // Column and row of a store address.
   function int addr_col(int addr);
      return addr % STORE_COLS;
   endfunction

   function int addr_row(int addr);
      return addr / STORE_COLS;
   endfunction

   // Store address of one neighborhood tap around the mapped source point.
   function int tap_addr(int col, int row, int dx, int dy);
      longint sx;
      longint sy;
      int     rx;
      int     ry;
      sx = (longint'(col) * longint'(src_cols())) / longint'(dst_cols());
      sy = (longint'(row) * longint'(src_rows())) / longint'(dst_rows());
      rx = clamp_to(sx + dx, src_cols());
      ry = clamp_to(sy + dy, src_rows());
      return ry * STORE_COLS + rx;
   endfunction

   // Apply one accepted request transaction in order.
   function void note_input(rwbm_pkg::req_payload_type t);
      int        addr;
      int        dx;
      int        dy;
      int        sum_r;
      int        sum_g;
      int        sum_b;
      bit [23:0] px;
      rgb_type   mean;
      if (t.opcode == rwbm_pkg::OP_STORE) begin
         if (takes_store(int'(t.col), int'(t.row))) begin
            addr = int'(t.row) * STORE_COLS + int'(t.col);
            pixels[addr]  = {t.in_red, t.in_green, t.in_blue};
            written[addr] = 1'b1;
         end
      end else begin
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
               px = pixels[tap_addr(int'(t.col), int'(t.row), dx, dy)];
               sum_r += px[23:16];
               sum_g += px[15:8];
               sum_b += px[7:0];
            end
         end
         mean.red   = 8'(sum_r / BOX_TAPS);
         mean.green = 8'(sum_g / BOX_TAPS);
         mean.blue  = 8'(sum_b / BOX_TAPS);
         owed_pixels.push_back(mean);
      end
   endfunction

   task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   // Compare one response transaction with the oldest owed pixel.
   task check_result(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      rgb_type want;
      if (owed_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected pixel %h %h %h", red, green, blue));
      end else begin
         want = owed_pixels.pop_front();
         if (red !== want.red)
            report_mismatch($sformatf("red %h, expected %h", red, want.red));
         if (green !== want.green)
            report_mismatch($sformatf("green %h, expected %h", green, want.green));
         if (blue !== want.blue)
            report_mismatch($sformatf("blue %h, expected %h", blue, want.blue));
      end
   endtask
endclass

module resize_with_box_mean_tb;
   import rwbm_pkg::*;

   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 190;

   logic clock;
   logic reset;

   rwbm_req_if req_bus ();
   rwbm_rsp_if rsp_bus ();
   rwbm_csr_if csr_bus ();

   box_mean_board board;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   int idle_cycles   = 0;

   // Size settings per phase; the last phase draws its own.
   int src_w_plan [PHASE_COUNT] = '{256, 1, 0, 511, 256, 200, 13, 0};
   int src_h_plan [PHASE_COUNT] = '{256, 1, 0, 511, 256, 37, 256, 0};
   int dst_w_plan [PHASE_COUNT] = '{256, 1, 0, 8191, 4096, 4095, 7, 0};
   int dst_h_plan [PHASE_COUNT] = '{256, 1, 0, 8191, 4096, 1, 300, 0};

   resize_with_box_mean dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Response back-pressure.
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // Result checking and a watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_result(rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("resize_with_box_mean_tb NOT OK");
               $finish;
            end
         end
      end
   end

   // Drive one request transaction; entered and left at a falling edge.
   task automatic send_item(req_payload_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.opcode   = t.opcode;
      req_bus.col      = t.col;
      req_bus.row      = t.row;
      req_bus.in_red   = t.in_red;
      req_bus.in_green = t.in_green;
      req_bus.in_blue  = t.in_blue;
      do @(posedge clock); while (!req_bus.ready);
      if (t.opcode == OP_COMPUTE || board.takes_store(int'(t.col), int'(t.row)))
         items_sent++;
      board.note_input(t);
      @(negedge clock);
   endtask

   task automatic send_store(int col, int row, logic [23:0] rgb);
      req_payload_type t;
      t.opcode = OP_STORE;
      t.col    = col[11:0];
      t.row    = row[11:0];
      {t.in_red, t.in_green, t.in_blue} = rgb;
      send_item(t);
   endtask

   // A compute only after every pixel of its neighborhood has been stored.
   task automatic send_compute(int col, int row);
      req_payload_type t;
      int              addr;
      int              dx;
      int              dy;
      for (dy = -1; dy <= 1; dy++) begin
         for (dx = -1; dx <= 1; dx++) begin
            addr = board.tap_addr(col, row, dx, dy);
            if (!board.written[addr])
               send_store(board.addr_col(addr), board.addr_row(addr), 24'($urandom));
         end
      end
      t.opcode = OP_COMPUTE;
      t.col    = col[11:0];
      t.row    = row[11:0];
      {t.in_red, t.in_green, t.in_blue} = 24'($urandom);
      send_item(t);
   endtask

   task automatic random_item();
      int choice;
      int col_top;
      int row_top;
      choice  = $urandom_range(99);
      col_top = (board.dst_cols() > 4096) ? 4095 : board.dst_cols() - 1;
      row_top = (board.dst_rows() > 4096) ? 4095 : board.dst_rows() - 1;
      if (choice < 60) begin
         if ($urandom_range(4) != 0)
            send_compute($urandom_range(col_top), $urandom_range(row_top));
         else
            send_compute($urandom_range(4095), $urandom_range(4095));
      end else if (choice < 85) begin
         send_store($urandom_range(board.src_cols() - 1), $urandom_range(board.src_rows() - 1),
                    24'($urandom));
      end else begin
         send_store($urandom_range(4095), $urandom_range(4095), 24'($urandom));
      end
   endtask

   task automatic write_csr(csr_index_type idx, int value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value[12:0];
      do @(posedge clock); while (!csr_bus.ready);
      board.write_reg(idx, csr_bus.data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Hold the request side until nothing is owed, then let the block drain.
   task automatic settle(int holdoff);
      req_bus.valid = 1'b0;
      while (board.owed_pixels.size() != 0) @(posedge clock);
      repeat (holdoff) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int phase;
      int target;
      bit paused;
      board            = new();
      paused           = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_STORE;
      req_bus.col      = '0;
      req_bus.row      = '0;
      req_bus.in_red   = '0;
      req_bus.in_green = '0;
      req_bus.in_blue  = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_SRC_WIDTH;
      csr_bus.data     = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: channel extremes, corners, stores outside the source, far destination.
      send_store(0, 0, 24'hFFFFFF);
      send_store(255, 255, 24'h000000);
      send_store(4095, 4095, 24'hFFFFFF);
      send_store(256, 0, 24'hFFFFFF);
      send_store(0, 256, 24'hFFFFFF);
      send_compute(0, 0);
      send_compute(255, 255);
      send_compute(4095, 4095);
      send_compute(128, 64);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            settle(SETTLE_CYCLES);
            if (phase == PHASE_COUNT - 1) begin
               write_csr(CSR_SRC_WIDTH, $urandom_range(511));
               write_csr(CSR_SRC_HEIGHT, $urandom_range(511));
               write_csr(CSR_DST_WIDTH, $urandom_range(8191));
               write_csr(CSR_DST_HEIGHT, $urandom_range(8191));
            end else begin
               write_csr(CSR_SRC_WIDTH, src_w_plan[phase]);
               write_csr(CSR_SRC_HEIGHT, src_h_plan[phase]);
               write_csr(CSR_DST_WIDTH, dst_w_plan[phase]);
               write_csr(CSR_DST_HEIGHT, dst_h_plan[phase]);
            end
         end
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 47;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 47;
            end
            default: begin
               send_idle_pct = 10;
               rsp_stall_pct = 10;
            end
         endcase
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            random_item();
            // Once, halfway through a phase, let every owed pixel come back.
            if (phase == 2 && !paused && items_sent >= target - ITEMS_PER_PHASE / 2) begin
               settle(0);
               paused = 1'b1;
            end
         end
      end

      settle(SETTLE_CYCLES);
      if (board.errors == 0)
         $display("resize_with_box_mean_tb OK");
      else
         $display("resize_with_box_mean_tb NOT OK");
      $finish;
   end
endmodule
